// ===== hdl/crlf_pkg.sv =====
package crlf_pkg;

	localparam int unsigned NUM_OUTPUTS_DEF  = 32;
	localparam int unsigned NUM_SWITCHES_DEF = 16;

	localparam int unsigned FRAME_MAX = 8;
	localparam int unsigned CFG_DW    = 32;
	localparam int unsigned CFG_AW    = 3;

	typedef enum logic [2:0] {
		FUNC_RX      = 3'd0,
		FUNC_LEVEL   = 3'd1,
		FUNC_SWITCH  = 3'd2,
		FUNC_PLUNGER = 3'd3,
		FUNC_GYRO_X  = 3'd4,
		FUNC_GYRO_Y  = 3'd5,
		FUNC_TICK    = 3'd6
	} func_t;

	typedef enum logic [CFG_AW-1:0] {
		REG_OWN_ID       = 3'd0,
		REG_PARTNER_ID   = 3'd1,
		REG_NIGHT_CMD    = 3'd2,
		REG_DEBUG_CMD    = 3'd3,
		REG_HB_CODE      = 3'd4,
		REG_FORCED_MASK  = 3'd5,
		REG_HB_INTERVAL  = 3'd6
	} reg_idx_t;

	localparam logic [7:0] TYPE_LEVEL   = 8'h10;
	localparam logic [7:0] TYPE_SWITCH  = 8'h20;
	localparam logic [7:0] TYPE_HID     = 8'h21;
	localparam logic [7:0] TYPE_PLUNGER = 8'h30;
	localparam logic [7:0] TYPE_GYRO_X  = 8'h31;
	localparam logic [7:0] TYPE_GYRO_Y  = 8'h32;

	localparam logic [7:0]  PARTNER_ID_RST  = 8'd12;
	localparam logic [7:0]  NIGHT_CMD_RST   = 8'd170;
	localparam logic [15:0] HB_INTERVAL_RST = 16'd500;
	localparam logic [15:0] PLUNGER_RST     = 16'hFFFF;
	localparam logic [15:0] GYRO_RST        = 16'h7FFF;

	// One item's worth of link bytes plus the flags reported with it
	typedef struct packed {
		logic [FRAME_MAX-1:0][7:0] bytes;
		logic [3:0]                count;
		logic                      night;
		logic                      debug;
	} frame_t;

endpackage

// ===== hdl/crlf_if.sv =====
interface crlf_event_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [4:0]  index;
	logic [15:0] value;
	logic [7:0]  hid_code;

	modport source (output valid, func, index, value, hid_code, input ready);
	modport sink   (input valid, func, index, value, hid_code, output ready);
endinterface

interface crlf_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       last;
	logic       night_flag;
	logic       debug_flag;

	modport source (output valid, out_byte, byte_valid, last, night_flag, debug_flag,
		input ready);
	modport sink   (input valid, out_byte, byte_valid, last, night_flag, debug_flag,
		output ready);
endinterface

// ===== hdl/change_report_link_framer.sv =====
// channel   dir  request payload
// --------  ---  ------------------------------------------------
// cfg_*     in   write enable, register index, 32-bit write data
// events    in   func, index, value, hid_code
// frames    out  out_byte, byte_valid, last, night_flag, debug_flag
//
// An accepted event is held in the input register, then is decoded in a
// single pass into 0, 2, 4 or 8 link bytes loaded into the result buffer.
// The buffer drains one result per cycle while the sink is ready; an event yields
// max(1, bytes) results, which pass from the input register through the buffer.
// The next event is taken while earlier results still wait in the buffer.
// Reset is asynchronous: config registers return to defaults, prior values to their seeds.
// A stalled result holds; the input register then holds and, once full, the input stalls.
module change_report_link_framer import crlf_pkg::*; #(
	parameter int unsigned NUM_OUTPUTS  = NUM_OUTPUTS_DEF,
	parameter int unsigned NUM_SWITCHES = NUM_SWITCHES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	crlf_event_if.sink        events,
	crlf_result_if.source     frames
);

	localparam int unsigned OUT_AW = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
	localparam int unsigned SW_AW  = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;

	typedef enum logic [2:0] {
		PH_ID  = 3'b001,
		PH_CMD = 3'b010,
		PH_VAL = 3'b100
	} phase_t;

	logic [7:0]  own_id_q;
	logic [7:0]  partner_id_q;
	logic [7:0]  night_cmd_q;
	logic [7:0]  debug_cmd_q;
	logic [7:0]  hb_code_q;
	logic [31:0] forced_q;
	logic [15:0] hb_interval_q;

	logic        valid_s1;
	logic [2:0]  func_s1;
	logic [4:0]  index_s1;
	logic [15:0] value_s1;
	logic [7:0]  hid_s1;

	logic [7:0]              levels_q [NUM_OUTPUTS];
	logic [NUM_SWITCHES-1:0] switches_q;
	logic [15:0]             plunger_q;
	logic [15:0]             gyro_x_q;
	logic [15:0]             gyro_y_q;
	phase_t                  phase_q;
	logic                    pend_debug_q;
	logic                    night_q;
	logic                    debug_q;
	logic [15:0]             tick_q;

	phase_t      phase_d;
	logic        pend_debug_d;
	logic        night_d;
	logic        debug_d;
	logic [15:0] tick_d;
	logic [15:0] tick_inc;
	logic        level_we;
	logic        sw_we;
	logic        plunger_we;
	logic        gyro_x_we;
	logic        gyro_y_we;
	logic        out_hit;
	logic        sw_hit;
	logic [7:0]  level;
	logic        pressed;
	logic [7:0]  number;
	logic [7:0]  rx_b;
	logic [7:0]  prior_level;
	logic        prior_sw;
	frame_t      frame_d;
	logic        buf_free;
	logic        fire;

	assign fire          = valid_s1 && buf_free;
	assign events.ready  = !valid_s1 || buf_free;

	assign out_hit     = {1'b0, index_s1} < 6'(NUM_OUTPUTS);
	assign sw_hit      = {1'b0, index_s1} < 6'(NUM_SWITCHES);
	assign level       = value_s1[7:0];
	assign rx_b        = value_s1[7:0];
	assign pressed     = |value_s1;
	assign number      = {3'b000, index_s1} + 8'd1;
	assign tick_inc    = tick_q + 16'd1;
	assign prior_level = levels_q[index_s1[OUT_AW-1:0]];
	assign prior_sw    = switches_q[index_s1[SW_AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q      <= 8'h00;
			partner_id_q  <= PARTNER_ID_RST;
			night_cmd_q   <= NIGHT_CMD_RST;
			debug_cmd_q   <= 8'h00;
			hb_code_q     <= 8'h00;
			forced_q      <= 32'h0;
			hb_interval_q <= HB_INTERVAL_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_OWN_ID:      own_id_q      <= cfg_data[7:0];
				REG_PARTNER_ID:  partner_id_q  <= cfg_data[7:0];
				REG_NIGHT_CMD:   night_cmd_q   <= cfg_data[7:0];
				REG_DEBUG_CMD:   debug_cmd_q   <= cfg_data[7:0];
				REG_HB_CODE:     hb_code_q     <= cfg_data[7:0];
				REG_FORCED_MASK: forced_q      <= cfg_data[31:0];
				REG_HB_INTERVAL: hb_interval_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (events.ready) begin
			valid_s1 <= events.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (events.valid && events.ready) begin
			func_s1  <= events.func;
			index_s1 <= events.index;
			value_s1 <= events.value;
			hid_s1   <= events.hid_code;
		end
	end

	always_comb begin
		frame_d          = '0;
		frame_d.bytes[0] = own_id_q;
		frame_d.bytes[4] = own_id_q;
		phase_d          = phase_q;
		pend_debug_d     = pend_debug_q;
		night_d          = night_q;
		debug_d          = debug_q;
		tick_d           = tick_q;
		level_we         = 1'b0;
		sw_we            = 1'b0;
		plunger_we       = 1'b0;
		gyro_x_we        = 1'b0;
		gyro_y_we        = 1'b0;
		case (func_t'(func_s1))
			FUNC_RX: begin
				case (phase_q)
					PH_CMD: begin
						if (rx_b == night_cmd_q || rx_b == debug_cmd_q) begin
							// night wins when both commands share a byte
							pend_debug_d = (rx_b != night_cmd_q);
							phase_d      = PH_VAL;
						end else begin
							phase_d = PH_ID;
						end
					end
					PH_VAL: begin
						if (pend_debug_q) begin
							debug_d = |rx_b;
						end else begin
							night_d = |rx_b;
						end
						phase_d = PH_ID;
					end
					default: begin
						phase_d = (rx_b == partner_id_q) ? PH_CMD : PH_ID;
					end
				endcase
			end
			FUNC_LEVEL: begin
				if (out_hit && level != prior_level) begin
					level_we = 1'b1;
					if (debug_q || forced_q[index_s1]) begin
						frame_d.count    = 4'd4;
						frame_d.bytes[1] = TYPE_LEVEL;
						frame_d.bytes[2] = number;
						frame_d.bytes[3] = level;
					end
				end
			end
			FUNC_SWITCH: begin
				if (debug_q && sw_hit && pressed != prior_sw) begin
					sw_we            = 1'b1;
					frame_d.count    = 4'd4;
					frame_d.bytes[1] = TYPE_SWITCH;
					frame_d.bytes[2] = number;
					frame_d.bytes[3] = {7'b0, pressed};
					if (pressed && hid_s1 != 8'h00) begin
						frame_d.count    = 4'd8;
						frame_d.bytes[5] = TYPE_HID;
						frame_d.bytes[6] = number;
						frame_d.bytes[7] = hid_s1;
					end
				end
			end
			FUNC_PLUNGER: begin
				if (debug_q && value_s1 != plunger_q) begin
					plunger_we       = 1'b1;
					frame_d.count    = 4'd4;
					frame_d.bytes[1] = TYPE_PLUNGER;
					frame_d.bytes[2] = value_s1[15:8];
					frame_d.bytes[3] = value_s1[7:0];
				end
			end
			FUNC_GYRO_X: begin
				if (debug_q && value_s1 != gyro_x_q) begin
					gyro_x_we        = 1'b1;
					frame_d.count    = 4'd4;
					frame_d.bytes[1] = TYPE_GYRO_X;
					frame_d.bytes[2] = value_s1[15:8];
					frame_d.bytes[3] = value_s1[7:0];
				end
			end
			FUNC_GYRO_Y: begin
				if (debug_q && value_s1 != gyro_y_q) begin
					gyro_y_we        = 1'b1;
					frame_d.count    = 4'd4;
					frame_d.bytes[1] = TYPE_GYRO_Y;
					frame_d.bytes[2] = value_s1[15:8];
					frame_d.bytes[3] = value_s1[7:0];
				end
			end
			FUNC_TICK: begin
				if (tick_inc >= hb_interval_q) begin
					tick_d           = 16'd0;
					frame_d.count    = 4'd2;
					frame_d.bytes[1] = hb_code_q;
				end else begin
					tick_d = tick_inc;
				end
			end
			default: ;
		endcase
		frame_d.night = night_d;
		frame_d.debug = debug_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_OUTPUTS; i++) begin
				levels_q[i] <= 8'h00;
			end
			switches_q   <= '0;
			plunger_q    <= PLUNGER_RST;
			gyro_x_q     <= GYRO_RST;
			gyro_y_q     <= GYRO_RST;
			phase_q      <= PH_ID;
			pend_debug_q <= 1'b0;
			night_q      <= 1'b0;
			debug_q      <= 1'b0;
			tick_q       <= 16'd0;
		end else if (fire) begin
			if (level_we) begin
				levels_q[index_s1[OUT_AW-1:0]] <= level;
			end
			if (sw_we) begin
				switches_q[index_s1[SW_AW-1:0]] <= pressed;
			end
			if (plunger_we) begin
				plunger_q <= value_s1;
			end
			if (gyro_x_we) begin
				gyro_x_q <= value_s1;
			end
			if (gyro_y_we) begin
				gyro_y_q <= value_s1;
			end
			phase_q      <= phase_d;
			pend_debug_q <= pend_debug_d;
			night_q      <= night_d;
			debug_q      <= debug_d;
			tick_q       <= tick_d;
		end
	end

	crlf_frame_buf u_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (fire),
		.frame  (frame_d),
		.free   (buf_free),
		.res    (frames)
	);

endmodule

// ===== hdl/crlf_frame_buf.sv =====
module crlf_frame_buf import crlf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   load,
	input  frame_t frame,
	output logic   free,
	crlf_result_if.source res
);

	logic                      valid_q;
	logic [3:0]                left_q;
	logic                      status_q;
	logic                      night_q;
	logic                      debug_q;
	logic [FRAME_MAX-1:0][7:0] bytes_q;
	logic                      pop;
	logic                      is_last;

	assign pop     = valid_q && res.ready;
	assign is_last = (left_q == 4'd1);
	assign free    = !valid_q || (pop && is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			left_q  <= 4'd1;
		end else if (load) begin
			valid_q <= 1'b1;
			left_q  <= (frame.count == 4'd0) ? 4'd1 : frame.count;
		end else if (pop) begin
			if (is_last) begin
				valid_q <= 1'b0;
			end else begin
				left_q <= left_q - 4'd1;
			end
		end
	end

	// Advance the byte queue by shifting; the head is always entry zero
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q  <= frame.bytes;
			status_q <= (frame.count == 4'd0);
			night_q  <= frame.night;
			debug_q  <= frame.debug;
		end else if (pop) begin
			bytes_q <= {8'h00, bytes_q[FRAME_MAX-1:1]};
		end
	end

	assign res.valid      = valid_q;
	assign res.out_byte   = status_q ? 8'h00 : bytes_q[0];
	assign res.byte_valid = !status_q;
	assign res.last       = is_last;
	assign res.night_flag = night_q;
	assign res.debug_flag = debug_q;

endmodule

// ===== hdl/crlf_checker.sv =====
module crlf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] res_out_byte,
	input logic       res_byte_valid,
	input logic       res_last,
	input logic       res_night,
	input logic       res_debug
);

	// a frame drains without gaps once its first byte is taken
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res_last |=> res_valid)
		else $error("frame drain broke before its last byte");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res_last
		|=> res_night == $past(res_night) && res_debug == $past(res_debug))
		else $error("flags changed inside one event's results");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_byte_valid |-> res_last && res_out_byte == 8'h00)
		else $error("status-only result is not a lone zero result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready
		|=> res_valid && $stable(res_out_byte) && $stable(res_last))
		else $error("stalled result request changed");

endmodule

bind change_report_link_framer crlf_checker u_crlf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (frames.valid),
	.res_ready      (frames.ready),
	.res_out_byte   (frames.out_byte),
	.res_byte_valid (frames.byte_valid),
	.res_last       (frames.last),
	.res_night      (frames.night_flag),
	.res_debug      (frames.debug_flag)
);
